// ===== src/leased_slot_ring_queue_assert.svh =====
// leased_slot_ring_queue_assert.svh: assertion macros for the leased slot ring queue
// no dependencies; included by the top level
`ifndef LEASED_SLOT_RING_QUEUE_ASSERT_SVH
`define LEASED_SLOT_RING_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LSRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define LSRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lsrq_pkg.sv =====
// lsrq_pkg: types and constants of the leased slot ring queue
// no dependencies; used by every module of the block
`default_nettype none

package lsrq_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam logic [4:0]  SLOTS_IN_USE_RESET     = 5'd16;
   localparam logic [31:0] EXPECTED_TYPE_RESET    = 32'd1;
   localparam logic [31:0] EXPECTED_VERSION_RESET = 32'd1;
   localparam logic [30:0] MAX_LENGTH_RESET       = 31'd4096;

   typedef enum logic [2:0] {
      CMD_RESERVE  = 3'd0,
      CMD_COMMIT   = 3'd1,
      CMD_CANCEL   = 3'd2,
      CMD_ACQUIRE  = 3'd3,
      CMD_RELEASE  = 3'd4,
      CMD_SHUTDOWN = 3'd5
   } lsrq_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_SHUT    = 2'd2,
      STATUS_BLOCK   = 2'd3
   } lsrq_status_type;

   typedef enum logic [1:0] {
      CSR_SLOTS_IN_USE     = 2'd0,
      CSR_EXPECTED_TYPE    = 2'd1,
      CSR_EXPECTED_VERSION = 2'd2,
      CSR_MAX_LENGTH       = 2'd3
   } lsrq_csr_index_type;

   typedef struct packed {
      logic [4:0]  slots_in_use;
      logic [31:0] expected_type;
      logic [31:0] expected_version;
      logic [30:0] max_length;
   } lsrq_cfg_type;

endpackage

`default_nettype wire

// ===== src/lsrq_csr.sv =====
// lsrq_csr: configuration registers of the leased slot ring queue
// depends on lsrq_pkg
`default_nettype none

module lsrq_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [31:0]          csr_wdata,
   output lsrq_pkg::lsrq_cfg_type    cfg
);
   import lsrq_pkg::*;

   lsrq_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slots_in_use     <= SLOTS_IN_USE_RESET;
         cfg_ff.expected_type    <= EXPECTED_TYPE_RESET;
         cfg_ff.expected_version <= EXPECTED_VERSION_RESET;
         cfg_ff.max_length       <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (lsrq_csr_index_type'(csr_index))
            CSR_SLOTS_IN_USE:     cfg_ff.slots_in_use     <= csr_wdata[4:0];
            CSR_EXPECTED_TYPE:    cfg_ff.expected_type    <= csr_wdata;
            CSR_EXPECTED_VERSION: cfg_ff.expected_version <= csr_wdata;
            CSR_MAX_LENGTH:       cfg_ff.max_length       <= csr_wdata[30:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/lsrq_len_ram.sv =====
// lsrq_len_ram: slot length store, one write and one registered read port
// depends on lsrq_pkg for the default depth
`default_nettype none

module lsrq_len_ram #(
   parameter  int SLOTS = lsrq_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [30:0]      wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      logic [30:0]      rd_data
);
   import lsrq_pkg::*;

   logic [30:0] len_mem [SLOTS];
   logic [30:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= len_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/lsrq_ctrl.sv =====
// lsrq_ctrl: lease, index and fill control, command decode and result registers
// depends on lsrq_pkg; drives the ports of lsrq_len_ram
`default_nettype none

module lsrq_ctrl #(
   parameter  int SLOTS = lsrq_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS),
   localparam int CNT_W = $clog2(SLOTS + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [2:0]             req_cmd,
   input  wire logic [31:0]            req_item_type,
   input  wire logic [31:0]            req_item_version,
   input  wire logic [30:0]            req_item_length,
   input  lsrq_pkg::lsrq_cfg_type      cfg,
   output      logic                   mem_we,
   output      logic [IDX_W-1:0]       mem_waddr,
   output      logic [30:0]            mem_wdata,
   output      logic                   mem_re,
   output      logic [IDX_W-1:0]       mem_raddr,
   output      logic                   rsp_valid,
   output      logic [1:0]             rsp_status,
   output      logic [IDX_W-1:0]       rsp_slot,
   output      logic [30:0]            rsp_capacity,
   output      logic [CNT_W-1:0]       rsp_fill,
   output      logic                   rsp_acq_ok
);
   import lsrq_pkg::*;

   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             prod_ff, prod_in;
   logic             cons_ff, cons_in;
   logic             shut_ff, shut_in;
   logic             valid_ff, valid_in;

   lsrq_status_type  status_ff, status_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [30:0]      cap_ff, cap_in;
   logic [CNT_W-1:0] occ_ff;
   logic             acq_ok_ff, acq_ok_in;

   logic [CMP_W-1:0] siu;
   logic [CNT_W-1:0] eff;
   logic             item_bad;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] nx;
      nx = CNT_W'(idx) + CNT_W'(1);
      return (nx >= lim) ? '0 : IDX_W'(nx);
   endfunction

   // effective wrap point, clamped to 2..SLOTS
   always_comb begin
      siu = CMP_W'(cfg.slots_in_use);
      if (siu < CMP_W'(2)) begin
         eff = CNT_W'(2);
      end else if (siu > CMP_W'(SLOTS)) begin
         eff = CNT_W'(SLOTS);
      end else begin
         eff = CNT_W'(siu);
      end
   end

   assign item_bad = (req_item_type != cfg.expected_type)
                  || (req_item_version != cfg.expected_version)
                  || (req_item_length == 31'd0)
                  || (req_item_length > cfg.max_length);

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      prod_in   = prod_ff;
      cons_in   = cons_ff;
      shut_in   = shut_ff;
      valid_in  = accept;
      status_in = STATUS_INVALID;
      slot_in   = '0;
      cap_in    = '0;
      acq_ok_in = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      if (accept) begin
         unique case (req_cmd)
            CMD_RESERVE: begin
               if (prod_ff) begin
                  status_in = STATUS_INVALID;
               end else if (shut_ff) begin
                  status_in = STATUS_SHUT;
               end else if (fill_ff >= eff) begin
                  status_in = STATUS_BLOCK;
               end else begin
                  status_in = STATUS_OK;
                  slot_in   = wr_idx_ff;
                  cap_in    = cfg.max_length;
                  prod_in   = 1'b1;
               end
            end
            CMD_COMMIT: begin
               if (!prod_ff || item_bad) begin
                  status_in = STATUS_INVALID;
               end else if (shut_ff) begin
                  status_in = STATUS_SHUT;
               end else begin
                  status_in = STATUS_OK;
                  mem_we    = 1'b1;
                  wr_idx_in = advance(wr_idx_ff, eff);
                  if (fill_ff < CNT_W'(SLOTS)) begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
                  prod_in   = 1'b0;
               end
            end
            CMD_CANCEL: begin
               status_in = STATUS_OK;
               prod_in   = 1'b0;
            end
            CMD_ACQUIRE: begin
               if (cons_ff) begin
                  status_in = STATUS_INVALID;
               end else if (fill_ff == '0) begin
                  status_in = shut_ff ? STATUS_SHUT : STATUS_BLOCK;
               end else begin
                  status_in = STATUS_OK;
                  slot_in   = rd_idx_ff;
                  mem_re    = 1'b1;
                  acq_ok_in = 1'b1;
                  cons_in   = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (!cons_ff) begin
                  status_in = STATUS_INVALID;
               end else begin
                  status_in = STATUS_OK;
                  rd_idx_in = advance(rd_idx_ff, eff);
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - CNT_W'(1);
                  end
                  cons_in   = 1'b0;
               end
            end
            CMD_SHUTDOWN: begin
               status_in = STATUS_OK;
               shut_in   = 1'b1;
            end
            default: begin
               status_in = STATUS_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         prod_ff   <= 1'b0;
         cons_ff   <= 1'b0;
         shut_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         prod_ff   <= prod_in;
         cons_ff   <= cons_in;
         shut_ff   <= shut_in;
         valid_ff  <= valid_in;
      end
   end

   // result payload, only meaningful under the strobe
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      cap_ff    <= cap_in;
      occ_ff    <= fill_in;
      acq_ok_ff <= acq_ok_in;
   end

   assign mem_waddr    = wr_idx_ff;
   assign mem_wdata    = req_item_length;
   assign mem_raddr    = rd_idx_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_capacity = cap_ff;
   assign rsp_fill     = occ_ff;
   assign rsp_acq_ok   = acq_ok_ff;

endmodule

`default_nettype wire

// ===== src/leased_slot_ring_queue.sv =====
// leased_slot_ring_queue: top level of the leased slot ring queue
// depends on lsrq_pkg, lsrq_csr, lsrq_ctrl, lsrq_len_ram and the assertion header
`default_nettype none
`include "leased_slot_ring_queue_assert.svh"

// A command is taken at every clock edge where start is high and busy is low;
// busy is high only while reset is asserted, so one command per cycle is
// sustained. Its result appears on the rsp_ ports in the following cycle,
// marked by rsp_valid for exactly that one cycle; the registered read port
// of the slot length RAM that acquire uses is read in step with the result
// registers. There is no way to hold results back, so sample them whenever
// rsp_valid is high. Configuration writes through csr_we take effect at once
// and must only be made while no command is in flight.
module leased_slot_ring_queue #(
   parameter int SLOTS = lsrq_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [31:0] req_item_type,
   input  wire logic [31:0] req_item_version,
   input  wire logic [30:0] req_item_length,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [3:0]  rsp_slot_index,
   output      logic [30:0] rsp_read_length,
   output      logic [30:0] rsp_capacity,
   output      logic [4:0]  rsp_occupied,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import lsrq_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   lsrq_cfg_type     cfg;
   logic             accept;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [30:0]      mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic [30:0]      mem_rdata;
   logic [IDX_W-1:0] rsp_slot;
   logic [CNT_W-1:0] rsp_fill;
   logic             rsp_acq_ok;

   assign busy   = reset;
   assign accept = start && !busy;

   lsrq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsrq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_item_type    (req_item_type),
      .req_item_version (req_item_version),
      .req_item_length  (req_item_length),
      .cfg              (cfg),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_re           (mem_re),
      .mem_raddr        (mem_raddr),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_capacity     (rsp_capacity),
      .rsp_fill         (rsp_fill),
      .rsp_acq_ok       (rsp_acq_ok)
   );

   lsrq_len_ram #(.SLOTS(SLOTS)) u_len_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // stored length only for a granted acquire
   assign rsp_read_length = rsp_acq_ok ? mem_rdata : 31'd0;
   assign rsp_slot_index  = 4'(rsp_slot);
   assign rsp_occupied    = 5'(rsp_fill);

   `LSRQ_ASSERT_NEXT(a_rsp_follows_accept, clock, reset, accept, rsp_valid,
                     "result strobe missing after accepted item")

   `LSRQ_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !accept, !rsp_valid,
                     "result strobe without accepted item")

   `LSRQ_ASSERT_NOW(a_fail_fields_zero, clock, reset,
                    rsp_valid && (rsp_status != STATUS_OK),
                    (rsp_slot_index == 4'd0) && (rsp_read_length == 31'd0)
                       && (rsp_capacity == 31'd0),
                    "failed command returned nonzero slot, length or capacity")

   `LSRQ_ASSERT_NEXT(a_ram_read_only_on_grant, clock, reset, mem_re,
                     rsp_acq_ok && (rsp_status == STATUS_OK),
                     "length read without a granted acquire result")

endmodule

`default_nettype wire
